// ===== rtl/bffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg: shared types and constants
// Sizes, codes and the controller/datapath handshake structs of the bitmap
// first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int BLOCK_KB   = 4;

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int RUN_W  = $clog2(NUM_BLOCKS + 1);
  localparam int SIZE_W = 11;
  localparam int NEED_W = SIZE_W;
  localparam int CMP_W  = (RUN_W > NEED_W) ? RUN_W : NEED_W;
  localparam int TAG_W  = 8;
  localparam int BLK_W  = 8;
  localparam int STAT_W = 2;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RELEASED  = 2'd3;

  typedef struct packed {
    logic load;
    logic clear_map;
    logic step;
    logic mark;
    logic emit;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_release;
    logic is_zero;
    logic hit;
    logic last_idx;
    logic mark_done;
  } bffa_stat_t;

  function automatic logic [BLK_W-1:0] to_blk(input logic [IDX_W-1:0] v);
    logic [IDX_W+BLK_W-1:0] ext;
    ext = {{BLK_W{1'b0}}, v};
    return ext[BLK_W-1:0];
  endfunction

endpackage

// ===== rtl/bitmap_first_fit_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top: first-fit contiguous block allocator
// Keeps one occupancy bit per block and serves allocate and release-all
// requests, one result beat per request beat.
// ----------------------------------------------------------------------------
// One request is handled at a time. The occupancy map is a memory with one
// write and one registered read per cycle, so after reset in_ready_o stays
// low during a clearing pass over every block. An allocate scans the map
// block by block from block 0 until the first free run of the rounded-up
// size is found, marks the blocks of that run and delivers the result, or
// delivers no-space after the last block. A release-all clears every block
// before its result; a zero-size request goes from accept straight to its
// result. A new request is taken once the result is in the output register,
// while that result waits for out_ready_i.
module bitmap_first_fit_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [bffa_pkg::TAG_W-1:0]        file_id_i,
  input  logic [bffa_pkg::SIZE_W-1:0]       size_kb_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bffa_pkg::STAT_W-1:0]       status_o,
  output logic [bffa_pkg::BLK_W-1:0]        first_block_o,
  output logic [bffa_pkg::BLK_W-1:0]        last_block_o,
  output logic [bffa_pkg::TAG_W-1:0]        tag_out_o
);

  bffa_pkg::bffa_cmd_t  cmd;
  bffa_pkg::bffa_stat_t stat;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bffa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .file_id_i     (file_id_i),
    .size_kb_i     (size_kb_i),
    .status_o      (status_o),
    .first_block_o (first_block_o),
    .last_block_o  (last_block_o),
    .tag_out_o     (tag_out_o)
  );

endmodule

// ===== rtl/bffa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp: allocator datapath
// Occupancy map, serial first-fit scan registers, range marking and the
// output payload register.
// ----------------------------------------------------------------------------
module bffa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bffa_pkg::bffa_cmd_t               cmd_i,
  output bffa_pkg::bffa_stat_t              stat_o,
  input  logic                              req_type_i,
  input  logic [bffa_pkg::TAG_W-1:0]        file_id_i,
  input  logic [bffa_pkg::SIZE_W-1:0]       size_kb_i,
  output logic [bffa_pkg::STAT_W-1:0]       status_o,
  output logic [bffa_pkg::BLK_W-1:0]        first_block_o,
  output logic [bffa_pkg::BLK_W-1:0]        last_block_o,
  output logic [bffa_pkg::TAG_W-1:0]        tag_out_o
);

  logic                            map_mem [bffa_pkg::NUM_BLOCKS];
  logic                            map_rd_q;
  logic [bffa_pkg::IDX_W-1:0]      idx_q, idx_d, idx_inc, run_start;
  logic [bffa_pkg::IDX_W-1:0]      start_q, last_q;
  logic [bffa_pkg::RUN_W-1:0]      run_q, run_inc;
  logic [bffa_pkg::NEED_W-1:0]     need_q, need_d;
  logic [bffa_pkg::SIZE_W:0]       size_sum;
  logic [bffa_pkg::TAG_W-1:0]      tag_q;
  logic [bffa_pkg::STAT_W-1:0]     res_q;
  logic                            bit_free, hit, wr_en, wr_bit;

  assign size_sum = {1'b0, size_kb_i} + (bffa_pkg::SIZE_W + 1)'(bffa_pkg::BLOCK_KB - 1);
  assign need_d   = bffa_pkg::NEED_W'(size_sum / bffa_pkg::BLOCK_KB);

  assign idx_inc   = idx_q + bffa_pkg::IDX_W'(1);
  assign run_start = (run_q == '0) ? idx_q : start_q;
  assign bit_free  = ~map_rd_q;
  assign run_inc   = run_q + bffa_pkg::RUN_W'(1);
  assign hit       = bit_free && (bffa_pkg::CMP_W'(run_inc) == bffa_pkg::CMP_W'(need_q));

  assign stat_o.is_release = (req_type_i == bffa_pkg::REQ_RELEASE);
  assign stat_o.is_zero    = (size_kb_i == '0);
  assign stat_o.hit        = hit;
  assign stat_o.last_idx   = (idx_q == bffa_pkg::IDX_W'(bffa_pkg::NUM_BLOCKS - 1));
  assign stat_o.mark_done  = (idx_q == last_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = hit ? run_start : idx_inc;
    end else if (cmd_i.clear_map || cmd_i.mark) begin
      idx_d = idx_inc;
    end
  end

  assign wr_en  = cmd_i.clear_map || cmd_i.mark;
  assign wr_bit = cmd_i.mark;

  // one entry written and one read per cycle, read data lines up with idx_q
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[idx_q] <= wr_bit;
    end
    map_rd_q <= map_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      run_q  <= '0;
      need_q <= need_d;
      tag_q  <= file_id_i;
      if (req_type_i == bffa_pkg::REQ_RELEASE) begin
        res_q <= bffa_pkg::ST_RELEASED;
      end else if (size_kb_i == '0) begin
        res_q <= bffa_pkg::ST_ZERO_SIZE;
      end else begin
        res_q <= bffa_pkg::ST_NO_SPACE;
      end
    end else if (cmd_i.step) begin
      if (bit_free) begin
        run_q   <= run_inc;
        start_q <= run_start;
      end else begin
        run_q <= '0;
      end
      if (hit) begin
        last_q <= idx_q;
        res_q  <= bffa_pkg::ST_ALLOCATED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o  <= res_q;
      tag_out_o <= tag_q;
      if (res_q == bffa_pkg::ST_ALLOCATED) begin
        first_block_o <= bffa_pkg::to_blk(start_q);
        last_block_o  <= bffa_pkg::to_blk(last_q);
      end else begin
        first_block_o <= '0;
        last_block_o  <= '0;
      end
    end
  end

endmodule

// ===== rtl/bffa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl: allocator controller
// Sequences accept, map scan, marking and result delivery; owns both
// handshakes.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  bffa_pkg::bffa_stat_t   stat_i,
  output bffa_pkg::bffa_cmd_t    cmd_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clear_map = 1'b1;
        if (stat_i.last_idx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (stat_i.is_release) begin
            state_d = S_CLEAR;
          end else if (stat_i.is_zero) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.hit) begin
          state_d = S_MARK;
        end else if (stat_i.last_idx) begin
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.mark_done) begin
          state_d = S_RESP;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_map = 1'b1;
        if (stat_i.last_idx) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
